// ----- rtl/core/first_fit_block_allocator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Each check is a real property in simulation and empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffba same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffba next-cycle check failed");
`else
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W = 24;
  localparam int SIZE_W = 20;

  // Request kinds carried on the input tuser bit.
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Register selects, taken from address bit 2.
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  // Result codes.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } fsm_t;

  // One block table entry as stored in the table memory.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffba_ctrl
// Controller of the allocator: accepts a request, runs the table walk,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t      cmd
);

  ffba_pkg::fsm_t state_r;
  ffba_pkg::fsm_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_SCAN: begin
        if (stat.done) begin
          state_nxt = ffba_pkg::S_RESP;
        end
      end
      ffba_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.scan     = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ffba_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ffba_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      ffba_pkg::S_RESP: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ffba_dp.sv -----
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath of the allocator: configuration registers, request registers,
// block table walk, append arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_top_assert.svh"

module ffba_dp #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [2:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic      [31:0]                  cfg_prdata,
  input  wire logic                         in_tuser,
  input  wire logic [47:0]                  in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [ffba_pkg::ADDR_W-1:0]  out_tdata,
  output logic      [1:0]                   out_tuser,
  input  wire ffba_pkg::cmd_t               cmd,
  output ffba_pkg::stat_t                   stat
);

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W  = ffba_pkg::ADDR_W + 1;
  localparam int ADDR_W = ffba_pkg::ADDR_W;
  localparam int SIZE_W = ffba_pkg::SIZE_W;

  // Configuration and heap state.
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] limit_r;
  logic [ADDR_W-1:0] break_r;
  logic [CNT_W-1:0]  count_r;

  // Request registers.
  logic              act_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] baddr_r;

  // Walk control.
  logic [CNT_W-1:0]  rd_idx_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              chk_vld_r;

  // Result and output registers.
  logic [ADDR_W-1:0]  res_addr_r;
  ffba_pkg::status_t  res_stat_r;
  logic [ADDR_W-1:0]  res_addr_nxt;
  ffba_pkg::status_t  res_stat_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  ffba_pkg::status_t  out_stat_r;
  logic               out_vld_r;

  // Table memory signals.
  logic                              rd_en;
  logic [$bits(ffba_pkg::entry_t)-1:0] rd_data;
  ffba_pkg::entry_t                  rd_entry;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_idx;
  ffba_pkg::entry_t                  wr_entry;

  logic              cfg_we;
  logic              base_we;
  logic              quick;
  logic              issue_more;
  logic              is_match;
  logic              hit;
  logic              miss;
  logic              done;
  logic              fits;
  logic              app_en;
  logic [SUM_W-1:0]  hdr_sum;
  logic [SUM_W-1:0]  end_sum;

  // Configuration writes and reads.
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite;
  assign base_we = cfg_we && (cfg_paddr[2] == ffba_pkg::REG_HEAP_BASE);
  assign cfg_prdata = (cfg_paddr[2] == ffba_pkg::REG_HEAP_LIMIT) ?
                      {8'd0, limit_r} : {8'd0, base_r};

  // Walk status over the registered table read.
  assign rd_entry   = ffba_pkg::entry_t'(rd_data);
  assign quick      = (act_r == ffba_pkg::ACT_ALLOC) ? (size_r == '0) : (baddr_r == '0);
  assign issue_more = rd_idx_r < count_r;
  assign is_match   = (act_r == ffba_pkg::ACT_ALLOC) ?
                      (rd_entry.free && (size_r <= rd_entry.size)) :
                      (rd_entry.addr == baddr_r);
  assign hit        = chk_vld_r && is_match;
  assign miss       = !chk_vld_r && !issue_more;
  assign done       = quick || hit || miss;
  assign rd_en      = cmd.scan && !done && issue_more;

  // Append arithmetic: header address and end of the new block.
  assign hdr_sum = {1'b0, break_r} + SUM_W'(HEADER_BYTES);
  assign end_sum = hdr_sum + SUM_W'(size_r);
  assign fits    = (count_r < CNT_W'(MAX_BLOCKS)) && (end_sum <= {1'b0, limit_r});

  // Decision for the cycle that ends the walk.
  always_comb begin
    wr_en        = 1'b0;
    wr_idx       = chk_idx_r;
    wr_entry     = rd_entry;
    app_en       = 1'b0;
    res_addr_nxt = '0;
    res_stat_nxt = ffba_pkg::ST_DONE;
    if (quick) begin
      if (act_r == ffba_pkg::ACT_ALLOC) begin
        res_stat_nxt = ffba_pkg::ST_ZERO;
      end
    end else if (hit) begin
      wr_en = cmd.scan;
      if (act_r == ffba_pkg::ACT_ALLOC) begin
        wr_entry.free = 1'b0;
        res_addr_nxt  = rd_entry.addr;
      end else begin
        wr_entry.free = 1'b1;
      end
    end else if (miss) begin
      if (act_r == ffba_pkg::ACT_RELEASE) begin
        res_stat_nxt = ffba_pkg::ST_NOTFOUND;
      end else if (fits) begin
        app_en        = cmd.scan;
        wr_en         = cmd.scan;
        wr_idx        = count_r[IDX_W-1:0];
        wr_entry.addr = hdr_sum[ADDR_W-1:0];
        wr_entry.size = size_r;
        wr_entry.free = 1'b0;
        res_addr_nxt  = hdr_sum[ADDR_W-1:0];
      end else begin
        res_stat_nxt = ffba_pkg::ST_NOSPACE;
      end
    end
  end

  // Block table.
  ffba_ram #(
    .WIDTH ($bits(ffba_pkg::entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Heap control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= '1;
      break_r <= '0;
      count_r <= '0;
    end else begin
      if (base_we) begin
        base_r <= cfg_pwdata[ADDR_W-1:0];
      end
      if (cfg_we && (cfg_paddr[2] == ffba_pkg::REG_HEAP_LIMIT)) begin
        limit_r <= cfg_pwdata[ADDR_W-1:0];
      end
      if (app_en) begin
        break_r <= end_sum[ADDR_W-1:0];
        count_r <= count_r + CNT_W'(1);
      end else if (base_we && (count_r == '0)) begin
        break_r <= cfg_pwdata[ADDR_W-1:0];
      end
    end
  end

  // Request capture and walk pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.accept) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      chk_vld_r <= rd_en;
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= in_tuser;
      size_r  <= in_tdata[SIZE_W-1:0];
      baddr_r <= in_tdata[SIZE_W+ADDR_W-1:SIZE_W];
    end
    if (rd_en) begin
      chk_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (cmd.scan && done) begin
      res_addr_r <= res_addr_nxt;
      res_stat_r <= res_stat_nxt;
    end
    if (cmd.out_load) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign stat.done     = done;
  assign stat.out_free = !out_vld_r || out_tready;
  assign out_tvalid    = out_vld_r;
  assign out_tdata     = out_addr_r;
  assign out_tuser     = out_stat_r;

  // The table never holds more blocks than it has rows.
  `FFBA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_BLOCKS))
  // An append grows the table by exactly one block.
  `FFBA_ASSERT_NXT(a_append_step, clk, rst_n, app_en, count_r == $past(count_r) + CNT_W'(1))
  // The break pointer moves only on an append or a base write to an empty table.
  `FFBA_ASSERT_NXT(a_break_hold, clk, rst_n, !app_en && !(base_we && (count_r == '0)), $stable(break_r))

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator with a bounded block table kept in
// allocation order, one result beat per request beat.
// ----------------------------------------------------------------------------
//
//   Channel  Protocol         Payload
//   in_      stream slave     tuser: action; tdata: req_size, block_addr
//   out_     stream master    tuser: status; tdata: data_addr
//   cfg_     APB-style slave  heap_base at 0x0, heap_limit at 0x4
//
// A zero size or a null release skips the table walk; otherwise the walk reads one table
// entry per cycle through the single read port, stopping at the first match. Reset is
// synchronous: counts clear, the break pointer and heap_base go to 0, heap_limit to all
// ones; the table memory itself is not cleared. While out_tready is low the result waits
// in the output register; one more request may be accepted and walked, and it then waits
// for the output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // req_size[19:0], block_addr[43:20], zero[47:44]
  input  wire logic        in_tuser,   // action
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // data_addr[23:0]
  output logic [1:0]       out_tuser   // status[1:0]
);

  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t stat;

  assign cfg_pready = 1'b1;

  // Controller.
  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  ffba_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire
